// File: design/lse_pkg.sv
// shared types and constants for the leading space entab block
package lse_pkg;

    localparam int TDATA_W = 24;
    localparam int OUT_W   = 8;

    localparam logic       REQ_CHAR  = 1'b0;
    localparam logic       REQ_STOP  = 1'b1;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [5:0] HELD_MAX  = 6'd63;
    localparam logic [6:0] RES_MAX   = 7'd64;
    localparam int         STOP_STEP = 4;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_SPACE = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       lend;
        logic [5:0] idx;
        logic [9:0] col;
    } item_t;

    typedef struct packed {
        logic in_leading;
        logic held_zero;
    } lse_stat_t;

endpackage

// File: design/leading_space_entab.sv
// top level of the leading space entab block
//
//  channel   dir  tdata                                      tuser      tlast
//  s_        in   char_code[7:0] stop_index[13:8]            req_type   line_end
//                 stop_column[23:14]
//  m_        out  out_char[7:0]                              -          last
//
// results leave through a one-result-per-cycle output register, and the tab-stop walk
// covers one stop per cycle; both pause while the output stalls. an item may first
// turn to the release of held spaces (a character after held spaces, or a line-ending
// space that is itself held). a two-entry queue lets input keep flowing while the
// output stalls. reset restores stops to every fourth column and starts a new line;
// no clearing pass is needed, so the block takes items right after reset.
module leading_space_entab #(
    parameter int NUM_STOPS = 64,
    parameter int COL_BITS  = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lse_pkg::TDATA_W-1:0] s_tdata,  // char_code, stop_index, stop_column
    input  logic                        s_tlast,
    input  logic                        s_tuser,  // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lse_pkg::OUT_W-1:0]   m_tdata,  // out_char
    output logic                        m_tlast
);
    import lse_pkg::*;

    logic      q_valid, q_pop;
    item_t     q_item;
    lse_stat_t stat;

    lse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lse_back #(
        .NUM_STOPS (NUM_STOPS),
        .COL_BITS  (COL_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    a_pop_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_item.kind != KIND_WRITE) && q_item.lend) |=> stat.in_leading)
        else $error("line end did not restart the leading region");

    a_held_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.in_leading |-> stat.held_zero)
        else $error("spaces still held after the leading region ended");

endmodule

// File: design/lse_front.sv
// input side: classifies each transfer and queues it for the back end
module lse_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lse_pkg::TDATA_W-1:0] s_tdata,
    input  logic                      s_tlast,
    input  logic                      s_tuser,
    output logic                      q_valid,
    output lse_pkg::item_t            q_item,
    input  logic                      q_pop
);
    import lse_pkg::*;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    always_comb begin
        in_item.ch   = s_tdata[7:0];
        in_item.idx  = s_tdata[13:8];
        in_item.col  = s_tdata[23:14];
        in_item.lend = s_tlast;
        if (s_tuser == REQ_STOP) begin
            in_item.kind = KIND_WRITE;
        end else if (s_tdata[7:0] == CH_SPACE) begin
            in_item.kind = KIND_SPACE;
        end else begin
            in_item.kind = KIND_CHAR;
        end
    end

    assign s_tready = (cnt_reg != QUEUE_DEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: design/lse_back.sv
// back end: stop table, line state, result sequencer and output register
module lse_back #(
    parameter int NUM_STOPS = 64,
    parameter int COL_BITS  = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  lse_pkg::item_t            q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lse_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output lse_pkg::lse_stat_t        stat
);
    import lse_pkg::*;

    localparam int AW  = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;
    localparam int NSW = $clog2(NUM_STOPS + 1);
    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TABS = 4'b0010,
        ST_REL  = 4'b0100,
        ST_CHAR = 4'b1000
    } state_t;

    function automatic logic [COL_BITS-1:0] reset_col(input logic [AW-1:0] a);
        logic [31:0] v;
        v = (32'(a) + 32'd1) * 32'(STOP_STEP);
        if (v > 32'(COL_MAX)) begin
            return COL_MAX;
        end
        return COL_BITS'(v);
    endfunction

    logic [COL_BITS-1:0] mem [NUM_STOPS];
    logic [NUM_STOPS-1:0] valid_reg;
    logic [COL_BITS-1:0] rd0_reg, rd1_reg;

    state_t              state_reg, state_next;
    logic                lead_reg, lead_next;
    logic [COL_BITS-1:0] cnt_reg, cnt_next;
    logic [NSW-1:0]      ns_reg, ns_next;
    logic [5:0]          held_reg, held_next;
    logic [6:0]          n_reg, n_next;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tlast_reg;

    logic                out_free, emit, e_last;
    logic [OUT_W-1:0]    e_char;
    logic                wr_en, wr_ok;
    logic [AW-1:0]       wr_addr, rd_a0, rd_a1;
    logic [COL_BITS-1:0] wr_col, cnt_inc, cmp_cnt;
    logic [NSW:0]        ns_p1, nsn_p1;
    logic                ns_in, ns1_in, hit0, hit1, lead_space;
    logic [8:0]          idx_ext;

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_ext  = 9'(q_item.idx);
    assign wr_ok    = idx_ext < 9'(NUM_STOPS);
    assign wr_addr  = AW'(q_item.idx);
    assign wr_col   = COL_BITS'(q_item.col);
    assign cnt_inc  = (cnt_reg < COL_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign cmp_cnt  = (state_reg == ST_IDLE) ? cnt_inc : cnt_reg;
    assign ns_p1    = {1'b0, ns_reg} + 1'b1;
    assign ns_in    = ns_reg < NSW'(NUM_STOPS);
    assign ns1_in   = ns_p1 < (NSW + 1)'(NUM_STOPS);
    assign hit0     = rd0_reg <= cmp_cnt;
    assign hit1     = ns1_in && (rd1_reg <= cmp_cnt);
    assign lead_space = lead_reg && (q_item.kind == KIND_SPACE);

    always_comb begin
        state_next = state_reg;
        lead_next  = lead_reg;
        cnt_next   = cnt_reg;
        ns_next    = ns_reg;
        held_next  = held_reg;
        n_next     = n_reg;
        emit       = 1'b0;
        e_char     = CH_SPACE;
        e_last     = 1'b0;
        q_pop      = 1'b0;
        wr_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    priority if (q_item.kind == KIND_WRITE) begin
                        wr_en = wr_ok;
                        q_pop = 1'b1;
                    end else if (lead_space) begin
                        cnt_next = cnt_inc;
                        if (!ns_in) begin
                            // past the last stop: spaces go straight out
                            emit   = 1'b1;
                            e_last = 1'b1;
                            q_pop  = 1'b1;
                        end else if (held_reg < HELD_MAX) begin
                            if (hit0) begin
                                emit      = 1'b1;
                                e_char    = CH_TAB;
                                ns_next   = NSW'(ns_p1);
                                held_next = '0;
                                n_next    = 7'd1;
                                if (hit1) begin
                                    state_next = ST_TABS;
                                end else begin
                                    e_last = 1'b1;
                                    q_pop  = 1'b1;
                                end
                            end else begin
                                held_next = held_reg + 1'b1;
                                if (q_item.lend) begin
                                    state_next = ST_REL;
                                end else begin
                                    q_pop = 1'b1;
                                end
                            end
                        end else begin
                            // holding is full, this space goes out now
                            emit   = 1'b1;
                            n_next = 7'd1;
                            if (hit0) begin
                                state_next = ST_TABS;
                            end else if (q_item.lend) begin
                                state_next = ST_REL;
                            end else begin
                                e_last = 1'b1;
                                q_pop  = 1'b1;
                            end
                        end
                    end else if (lead_reg && (held_reg != '0)) begin
                        state_next = ST_REL;
                    end else begin
                        emit      = 1'b1;
                        e_char    = q_item.ch;
                        e_last    = 1'b1;
                        lead_next = 1'b0;
                        q_pop     = 1'b1;
                    end
                end
            end
            ST_TABS: begin
                emit      = 1'b1;
                e_char    = CH_TAB;
                ns_next   = NSW'(ns_p1);
                held_next = '0;
                n_next    = n_reg + 1'b1;
                if (!(hit1 && (7'(n_reg + 1'b1) < RES_MAX))) begin
                    e_last     = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REL: begin
                emit      = 1'b1;
                held_next = held_reg - 1'b1;
                n_next    = n_reg + 1'b1;
                if (held_reg == 6'd1) begin
                    if (q_item.kind == KIND_CHAR) begin
                        state_next = ST_CHAR;
                    end else begin
                        e_last     = 1'b1;
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHAR: begin
                emit       = 1'b1;
                e_char     = q_item.ch;
                e_last     = 1'b1;
                lead_next  = 1'b0;
                q_pop      = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // end of line restarts the leading region
        if (q_pop && (q_item.kind != KIND_WRITE) && q_item.lend) begin
            lead_next = 1'b1;
            cnt_next  = '0;
            ns_next   = '0;
            held_next = '0;
        end
        if (q_pop) begin
            n_next = '0;
        end

        // output slot busy: hold everything this cycle
        if (emit && !out_free) begin
            state_next = state_reg;
            lead_next  = lead_reg;
            cnt_next   = cnt_reg;
            ns_next    = ns_reg;
            held_next  = held_reg;
            n_next     = n_reg;
            emit       = 1'b0;
            q_pop      = 1'b0;
            wr_en      = 1'b0;
        end
    end

    // prefetch the stop at the next pointer and the one after it
    assign nsn_p1 = {1'b0, ns_next} + 1'b1;
    assign rd_a0  = (ns_next < NSW'(NUM_STOPS)) ? AW'(ns_next) : '0;
    assign rd_a1  = (nsn_p1 < (NSW + 1)'(NUM_STOPS)) ? AW'(nsn_p1) : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_col;
        end
        if (wr_en && (wr_addr == rd_a0)) begin
            rd0_reg <= wr_col;
        end else if (valid_reg[rd_a0]) begin
            rd0_reg <= mem[rd_a0];
        end else begin
            rd0_reg <= reset_col(rd_a0);
        end
        if (wr_en && (wr_addr == rd_a1)) begin
            rd1_reg <= wr_col;
        end else if (valid_reg[rd_a1]) begin
            rd1_reg <= mem[rd_a1];
        end else begin
            rd1_reg <= reset_col(rd_a1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lead_reg     <= 1'b1;
            cnt_reg      <= '0;
            ns_reg       <= '0;
            held_reg     <= '0;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lead_reg  <= lead_next;
            cnt_reg   <= cnt_next;
            ns_reg    <= ns_next;
            held_reg  <= held_next;
            n_reg     <= n_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= e_char;
            m_tlast_reg <= e_last;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = m_tdata_reg;
    assign m_tlast        = m_tlast_reg;
    assign stat.in_leading = lead_reg;
    assign stat.held_zero  = (held_reg == '0);

endmodule
